// ===== src/afr_pkg.sv =====
`timescale 1ns / 1ps

package afr_pkg;

   // Frame store depth and derived widths
   localparam int BUF_DEPTH = 64;
   localparam int IDX_W     = $clog2(BUF_DEPTH);
   localparam int POS_W     = $clog2(BUF_DEPTH + 1);

   localparam logic [7:0] CSUM_BASE         = 8'hFF;
   localparam logic [7:0] START_BYTE_RST    = 8'h7E;
   localparam logic [7:0] ACCEPTED_API_RST  = 8'h81;
   localparam int         API_POS           = 3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_BYTE   = 1'd0,
      CSR_ACCEPTED_API = 1'd1
   } csr_idx_type;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_ABORT = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // Result kinds
   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   // Frame status codes
   typedef enum logic [1:0] {
      ST_GOOD_ACCEPTED = 2'd0,
      ST_GOOD_OTHER    = 2'd1,
      ST_BAD_CSUM      = 2'd2
   } status_type;

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_WAIT   = 4'b0001,
      PH_LEN_HI = 4'b0010,
      PH_LEN_LO = 4'b0100,
      PH_DATA   = 4'b1000
   } phase_type;

   // Control from the parser to the frame banks
   typedef struct packed {
      logic wr_en;        // store one frame byte in the receive side
      logic commit;       // frame end: receive side becomes the readable store
      logic clear;        // abort: both stores read as zero
      logic rd_en;        // read the readable store
      logic rd_in_range;  // read index lies inside the store
   } bank_ctl_type;

endpackage

// ===== src/afr_frame_banks.sv =====
`timescale 1ns / 1ps

module afr_frame_banks
   import afr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bank_ctl_type     ctl,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   // Two banks per entry: loc says which bank holds the readable byte,
   // the other bank takes receive writes. wr marks entries written since
   // the last frame end, zero marks entries cleared by abort or reset.
   logic [7:0] mem0 [BUF_DEPTH];
   logic [7:0] mem1 [BUF_DEPTH];

   logic [BUF_DEPTH-1:0] loc_ff, loc_in;
   logic [BUF_DEPTH-1:0] wr_ff, wr_in;
   logic [BUF_DEPTH-1:0] zero_ff, zero_in;

   logic [7:0] q0_ff;
   logic [7:0] q1_ff;
   logic       sel_ff;
   logic       rd_zero_ff;

   always_comb begin
      logic hit;
      loc_in  = loc_ff;
      wr_in   = wr_ff;
      zero_in = zero_ff;
      for (int i = 0; i < BUF_DEPTH; i++) begin
         hit = ctl.wr_en && (wr_addr == IDX_W'(i));
         if (ctl.clear) begin
            wr_in[i]   = 1'b0;
            zero_in[i] = 1'b1;
         end else if (ctl.commit) begin
            if (wr_ff[i] || hit) begin
               loc_in[i]  = ~loc_ff[i];
               zero_in[i] = 1'b0;
            end
            wr_in[i] = 1'b0;
         end else if (hit) begin
            wr_in[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_ff  <= '0;
         wr_ff   <= '0;
         zero_ff <= '1;
      end else begin
         loc_ff  <= loc_in;
         wr_ff   <= wr_in;
         zero_ff <= zero_in;
      end
   end

   // Receive writes go to the bank opposite loc
   always_ff @(posedge clock) begin
      if (ctl.wr_en && loc_ff[wr_addr]) begin
         mem0[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         q0_ff <= mem0[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en && !loc_ff[wr_addr]) begin
         mem1[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         q1_ff <= mem1[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         sel_ff     <= loc_ff[rd_addr];
         rd_zero_ff <= zero_ff[rd_addr] | ~ctl.rd_in_range;
      end
   end

   assign rd_data = rd_zero_ff ? 8'd0 : (sel_ff ? q1_ff : q0_ff);

   a_clear_marks: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (wr_ff == '0) && (zero_ff == '1))
      else $error("abort left written or live entries");

   a_commit_marks: assert property (@(posedge clock) disable iff (reset)
      ctl.commit && !ctl.clear |=> wr_ff == '0)
      else $error("frame end left written marks");

   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en && !ctl.commit && !ctl.clear |=> wr_ff != '0)
      else $error("receive write not marked");

endmodule

// ===== src/api_frame_receiver.sv =====
`timescale 1ns / 1ps
// A result word is registered and appears on rsp in the cycle after the request word is taken.
// Throughput: one request word per cycle; the request side stalls only while a
//   result word is held on rsp under rsp_stall.
// Reset (synchronous): parser back to hunting for the start byte, both frame stores
//   read as zero at once through per-entry flags, start_byte 0x7E, accepted_api 0x81.
module api_frame_receiver
   import afr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [7:0]           req_rx_byte,
   input  logic [5:0]           req_read_index,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_result_kind,
   output logic [1:0]           rsp_frame_status,
   output logic [15:0]          rsp_frame_length,
   output logic                 rsp_overflow,
   output logic [7:0]           rsp_read_data
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0] start_byte_ff;
   logic [7:0] accepted_api_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= START_BYTE_RST;
         accepted_api_ff <= ACCEPTED_API_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_BYTE:   start_byte_ff   <= csr_wdata;
            CSR_ACCEPTED_API: accepted_api_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------
   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] wpos_ff, wpos_in;       // next buffer position, saturates
   logic [15:0]      remain_ff, remain_in;   // payload bytes still expected
   logic [15:0]      plen_ff, plen_in;       // length field of this frame
   logic [7:0]       sum_ff, sum_in;         // payload sum modulo 256
   logic             ovf_ff, ovf_in;         // a byte of this frame was dropped
   logic [7:0]       len_hi_ff, len_hi_in;   // length MSB, buffer position one
   logic [7:0]       api_ff, api_in;         // byte at the API id position

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         kind_ff, kind_in;
   status_type       status_ff, status_in;
   logic [15:0]      len_ff, len_in;
   logic             rovf_ff, rovf_in;

   logic             accept;
   logic             has_result;
   bank_ctl_type     bank_ctl;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       bank_rd_data;

   // Hold the request side only while a result word waits under stall
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign wr_addr = wpos_ff[IDX_W-1:0];
   assign rd_addr = IDX_W'(req_read_index);

   always_comb begin
      logic       room;
      logic [7:0] api_id;
      logic [7:0] expect_sum;

      phase_in   = phase_ff;
      wpos_in    = wpos_ff;
      remain_in  = remain_ff;
      plen_in    = plen_ff;
      sum_in     = sum_ff;
      ovf_in     = ovf_ff;
      len_hi_in  = len_hi_ff;
      api_in     = api_ff;
      bank_ctl   = '0;
      has_result = 1'b0;
      kind_in    = KIND_REPORT;
      status_in  = ST_GOOD_ACCEPTED;
      len_in     = 16'd0;
      rovf_in    = 1'b0;

      room       = (32'(wpos_ff) < BUF_DEPTH);
      api_id     = (wpos_ff == POS_W'(API_POS)) ? req_rx_byte : api_ff;
      expect_sum = CSUM_BASE - sum_ff;

      if (accept) begin
         case (req_op)
            OP_ABORT: begin
               // Drop the frame in progress and clear both stores
               phase_in       = PH_WAIT;
               wpos_in        = '0;
               remain_in      = '0;
               plen_in        = '0;
               sum_in         = '0;
               ovf_in         = 1'b0;
               bank_ctl.clear = 1'b1;
            end
            OP_READ: begin
               has_result           = 1'b1;
               kind_in              = KIND_READ;
               bank_ctl.rd_en       = 1'b1;
               bank_ctl.rd_in_range = (32'(req_read_index) < BUF_DEPTH);
            end
            OP_BYTE: begin
               if (phase_ff == PH_WAIT) begin
                  // Every hunted byte lands at position zero
                  bank_ctl.wr_en = 1'b1;
                  if (req_rx_byte == start_byte_ff) begin
                     wpos_in  = POS_W'(1);
                     ovf_in   = 1'b0;
                     phase_in = PH_LEN_HI;
                  end
               end else begin
                  // Store and advance, or drop and flag once the buffer is full
                  if (room) begin
                     bank_ctl.wr_en = 1'b1;
                     wpos_in        = wpos_ff + POS_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  unique case (phase_ff)
                     PH_LEN_HI: begin
                        len_hi_in = req_rx_byte;
                        phase_in  = PH_LEN_LO;
                     end
                     PH_LEN_LO: begin
                        plen_in   = {len_hi_ff, req_rx_byte};
                        remain_in = {len_hi_ff, req_rx_byte};
                        sum_in    = 8'd0;
                        phase_in  = PH_DATA;
                     end
                     PH_DATA: begin
                        if (wpos_ff == POS_W'(API_POS)) begin
                           api_in = req_rx_byte;
                        end
                        if (remain_ff != 16'd0) begin
                           sum_in    = sum_ff + req_rx_byte;
                           remain_in = remain_ff - 16'd1;
                        end else begin
                           // Checksum byte: report and swap banks
                           has_result      = 1'b1;
                           bank_ctl.commit = 1'b1;
                           if (expect_sum != req_rx_byte) begin
                              status_in = ST_BAD_CSUM;
                           end else if (api_id == accepted_api_ff) begin
                              status_in = ST_GOOD_ACCEPTED;
                           end else begin
                              status_in = ST_GOOD_OTHER;
                           end
                           len_in   = plen_ff;
                           rovf_in  = ovf_in;
                           phase_in = PH_WAIT;
                           wpos_in  = '0;
                        end
                     end
                     default: begin
                        phase_in = PH_WAIT;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end

      // Result register: load on accept, empty once taken
      if (accept) begin
         rsp_valid_in = has_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         wpos_ff      <= '0;
         remain_ff    <= '0;
         plen_ff      <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wpos_ff      <= wpos_in;
         remain_ff    <= remain_in;
         plen_ff      <= plen_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      len_hi_ff <= len_hi_in;
      api_ff    <= api_in;
      if (accept) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         len_ff    <= len_in;
         rovf_ff   <= rovf_in;
      end
   end

   // ---------------------------------------------------------------
   // Receive buffer and readable frame store
   // ---------------------------------------------------------------
   afr_frame_banks u_banks (
      .clock   (clock),
      .reset   (reset),
      .ctl     (bank_ctl),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (bank_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_frame_length = len_ff;
   assign rsp_overflow     = rovf_ff;
   assign rsp_read_data    = (kind_ff == KIND_READ) ? bank_rd_data : 8'd0;

   a_wait_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT |-> wpos_ff == '0)
      else $error("write position not zero while hunting");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(wpos_ff) <= BUF_DEPTH)
      else $error("write position beyond buffer depth");

   a_abort: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == OP_ABORT) |=> (phase_ff == PH_WAIT) && !rsp_valid)
      else $error("abort did not return parser to hunting");

endmodule
